// ===== rtl/bse_pkg.sv =====
package bse_pkg;

	// field widths of the command and result beats
	localparam int CMD_W   = 3;
	localparam int ELEM_W  = 8;
	localparam int RANK_W  = 9;
	localparam int COUNT_W = 9;
	localparam int POS_W   = 8;

	// command codes
	localparam logic [CMD_W-1:0] CMD_ADD        = 3'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_TEST       = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd3;
	localparam logic [CMD_W-1:0] CMD_COMPLEMENT = 3'd4;
	localparam logic [CMD_W-1:0] CMD_SELECT     = 3'd5;

	// sequencer states
	typedef enum logic [1:0] {
		ST_WIPE,
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} bse_state_t;

endpackage

// ===== rtl/bitmap_set_engine.sv =====
// channel | beat fields (lowest bit up)                          | handshake
// s       | tuser: cmd[2:0]; tdata: element[7:0], rank[16:8]     | s_tvalid / s_tready
// m       | tdata: is_member, member_count[9:1], is_empty,       | m_tvalid / m_tready
//         |   lowest_member[18:11], lowest_found, nth_member     |
//         |   [27:20], nth_found[28]                              |
//
// each command makes one sweep over the word memory, one read-modify-write per cycle,
// through a single word unit that updates, counts and searches each word
// after reset the block wipes every word of the memory before s_tready rises
// s_tready is high only while no command is in flight; a result held by a stalled
// m side blocks the next command from completing but not from being accepted
module bitmap_set_engine
	import bse_pkg::*;
#(
	parameter int WORD_BITS  = 8,
	parameter int WORD_COUNT = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // element[7:0], rank[16:8], zeros
	input  logic [2:0]  s_tuser,  // cmd[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // is_member, member_count, is_empty, lowest_member,
	                              // lowest_found, nth_member, nth_found, zeros
);

	localparam int SET_BITS = WORD_BITS * WORD_COUNT;
	localparam int CW = $clog2(SET_BITS + 1);
	localparam int IW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int BW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
	localparam int KW = $clog2(WORD_BITS + 1);
	localparam int AW = CW + RANK_W + 1;

	bse_state_t state_q, state_d;

	logic [WORD_BITS-1:0] mem [WORD_COUNT];

	logic [IW-1:0]        rd_idx_q;
	logic                 issue_done_q;
	logic                 vld_s1;
	logic [IW-1:0]        widx_s1;
	logic [WORD_BITS-1:0] rdata_s1;
	logic [CW-1:0]        base_q;
	logic [CW-1:0]        seen_q;
	logic                 low_found_q;
	logic [CW-1:0]        low_pos_q;
	logic                 nth_found_q;
	logic [CW-1:0]        nth_pos_q;
	logic                 member_q;

	logic [CMD_W-1:0]  cmd_q;
	logic [ELEM_W-1:0] element_q;
	logic [RANK_W-1:0] rank_q;

	logic               out_valid_q;
	logic               out_member_q;
	logic [COUNT_W-1:0] out_count_q;
	logic               out_empty_q;
	logic [POS_W-1:0]   out_low_q;
	logic               out_low_found_q;
	logic [POS_W-1:0]   out_nth_q;
	logic               out_nth_found_q;

	// sequencer controls
	logic accept;
	logic rd_en;
	logic wr_en;
	logic wipe_last;
	logic scan_last;
	logic load_out;

	// word unit signals
	logic [AW-1:0]        elem_diff;
	logic                 elem_hit;
	logic [BW-1:0]        bit_idx;
	logic [WORD_BITS-1:0] new_word;
	logic [WORD_BITS-1:0] wr_data;
	logic [IW-1:0]        wr_addr;
	logic [KW-1:0]        word_cnt;
	logic [BW-1:0]        low_bit;
	logic                 word_nonzero;
	logic [AW-1:0]        rank_x;
	logic [AW-1:0]        seen_x;
	logic [AW-1:0]        total_x;
	logic [AW-1:0]        need_x;
	logic                 rank_hit;
	logic [BW-1:0]        sel_bit;

	// result formatting
	logic [CW+COUNT_W-1:0] seen_ext;
	logic [CW+POS_W-1:0]   low_ext;
	logic [CW+POS_W-1:0]   nth_ext;

	assign accept    = s_tvalid && s_tready;
	assign wipe_last = (rd_idx_q == IW'(WORD_COUNT - 1));
	assign scan_last = vld_s1 && (widx_s1 == IW'(WORD_COUNT - 1));

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WIPE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and sequencer outputs
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		rd_en    = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_WIPE: begin
				if (wipe_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_en = !issue_done_q;
				if (scan_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// word memory, registered read
	assign wr_en   = (state_q == ST_WIPE) || vld_s1;
	assign wr_addr = (state_q == ST_WIPE) ? rd_idx_q : widx_s1;
	assign wr_data = (state_q == ST_WIPE) ? '0 : new_word;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_idx_q];
		end
	end

	// locate the named element in the word under the unit
	always_comb begin
		elem_diff = AW'(element_q) - AW'(base_q);
		elem_hit  = !elem_diff[AW-1] && (elem_diff < AW'(WORD_BITS));
		bit_idx   = elem_diff[BW-1:0];
	end

	// apply the command to the word
	always_comb begin
		new_word = rdata_s1;
		unique case (cmd_q)
			CMD_ADD: begin
				for (int j = 0; j < WORD_BITS; j++) begin
					if (elem_hit && (bit_idx == BW'(j))) begin
						new_word[j] = 1'b1;
					end
				end
			end
			CMD_REMOVE: begin
				for (int j = 0; j < WORD_BITS; j++) begin
					if (elem_hit && (bit_idx == BW'(j))) begin
						new_word[j] = 1'b0;
					end
				end
			end
			CMD_CLEAR:      new_word = '0;
			CMD_COMPLEMENT: new_word = ~rdata_s1;
			CMD_TEST, CMD_SELECT: new_word = rdata_s1;
			default:        new_word = rdata_s1;
		endcase
	end

	// population count and lowest set bit of the updated word
	always_comb begin
		word_cnt = '0;
		low_bit  = '0;
		for (int j = 0; j < WORD_BITS; j++) begin
			word_cnt = word_cnt + KW'(new_word[j]);
		end
		for (int j = WORD_BITS - 1; j >= 0; j--) begin
			if (new_word[j]) begin
				low_bit = BW'(j);
			end
		end
		word_nonzero = |new_word;
	end

	// does the sought rank fall in this word, and at which bit
	always_comb begin
		logic [KW-1:0] pre;
		rank_x   = AW'(rank_q);
		seen_x   = AW'(seen_q);
		total_x  = seen_x + AW'(word_cnt);
		rank_hit = (rank_q != '0) && (rank_x > seen_x) && (rank_x <= total_x);
		need_x   = rank_x - seen_x - AW'(1);
		sel_bit  = '0;
		for (int j = 0; j < WORD_BITS; j++) begin
			pre = '0;
			for (int k = 0; k < j; k++) begin
				pre = pre + KW'(new_word[k]);
			end
			if (new_word[j] && (pre == need_x[KW-1:0])) begin
				sel_bit = BW'(j);
			end
		end
	end

	// sweep counters and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q     <= '0;
			issue_done_q <= 1'b0;
			vld_s1       <= 1'b0;
			widx_s1      <= '0;
			base_q       <= '0;
			seen_q       <= '0;
			low_found_q  <= 1'b0;
			low_pos_q    <= '0;
			nth_found_q  <= 1'b0;
			nth_pos_q    <= '0;
			member_q     <= 1'b0;
			cmd_q        <= CMD_TEST;
			element_q    <= '0;
			rank_q       <= '0;
		end else begin
			vld_s1  <= rd_en;
			widx_s1 <= rd_idx_q;
			if (state_q == ST_WIPE) begin
				rd_idx_q <= wipe_last ? '0 : rd_idx_q + IW'(1);
			end
			if (accept) begin
				cmd_q        <= s_tuser[CMD_W-1:0];
				element_q    <= s_tdata[ELEM_W-1:0];
				rank_q       <= s_tdata[ELEM_W+RANK_W-1:ELEM_W];
				rd_idx_q     <= '0;
				issue_done_q <= 1'b0;
				base_q       <= '0;
				seen_q       <= '0;
				low_found_q  <= 1'b0;
				low_pos_q    <= '0;
				nth_found_q  <= 1'b0;
				nth_pos_q    <= '0;
				member_q     <= 1'b0;
			end
			if (rd_en) begin
				if (rd_idx_q == IW'(WORD_COUNT - 1)) begin
					issue_done_q <= 1'b1;
				end else begin
					rd_idx_q <= rd_idx_q + IW'(1);
				end
			end
			if (vld_s1) begin
				base_q <= base_q + CW'(WORD_BITS);
				seen_q <= total_x[CW-1:0];
				if (elem_hit) begin
					member_q <= new_word[bit_idx];
				end
				if (!low_found_q && word_nonzero) begin
					low_found_q <= 1'b1;
					low_pos_q   <= base_q + CW'(low_bit);
				end
				if ((cmd_q == CMD_SELECT) && !nth_found_q && rank_hit) begin
					nth_found_q <= 1'b1;
					nth_pos_q   <= base_q + CW'(sel_bit);
				end
			end
		end
	end

	// saturate the count and mask positions to the result widths
	assign seen_ext = {{COUNT_W{1'b0}}, seen_q};
	assign low_ext  = {{POS_W{1'b0}}, low_pos_q};
	assign nth_ext  = {{POS_W{1'b0}}, nth_pos_q};

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_member_q    <= member_q;
			out_count_q     <= (seen_ext > (CW + COUNT_W)'(511)) ? COUNT_W'(511)
			                                                      : seen_ext[COUNT_W-1:0];
			out_empty_q     <= (seen_q == '0);
			out_low_q       <= low_ext[POS_W-1:0];
			out_low_found_q <= low_found_q;
			out_nth_q       <= nth_ext[POS_W-1:0];
			out_nth_found_q <= nth_found_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_nth_found_q, out_nth_q, out_low_found_q, out_low_q,
	                   out_empty_q, out_count_q, out_member_q};

	// a new beat always starts a sweep
	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_SCAN))
		else $error("accepted beat did not start a sweep");

	// word unit only works during a sweep
	a_unit_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == ST_SCAN))
		else $error("word unit active outside a sweep");

	// a result has a lowest member exactly when it is not empty
	a_low_vs_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_low_found_q != out_empty_q))
		else $error("lowest flag disagrees with empty flag");

	// select hits are only reported for select commands
	a_nth_select: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && nth_found_q |-> (cmd_q == CMD_SELECT))
		else $error("nth member found for a command other than select");

endmodule

// ===== tb/sv/bse_report_checker.sv =====
module bse_report_checker
	import bse_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,  // element[7:0], rank[16:8], zeros
	input  logic [2:0]  s_tuser,  // cmd[2:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,  // is_member, member_count, is_empty, lowest_member,
	                              // lowest_found, nth_member, nth_found, zeros
	output int          fail_count,
	output int          outstanding,
	output int          result_count
);

	timeunit 1ns;
	timeprecision 1ps;

	// one result beat, is_member in the lowest bit
	typedef struct packed {
		logic              nth_found;
		logic [POS_W-1:0]  nth_member;
		logic              lowest_found;
		logic [POS_W-1:0]  lowest_member;
		logic              is_empty;
		logic [COUNT_W-1:0] member_count;
		logic              is_member;
	} set_report_t;

	localparam int SET_SIZE = 256;

	logic [SET_SIZE-1:0] member_bits;
	set_report_t         expected_reports[$];

	initial begin
		fail_count   = 0;
		outstanding  = 0;
		result_count = 0;
		member_bits  = '0;
	end

	// apply one command to the shadow bitmap and work out the report it gives
	function automatic set_report_t report_after(input logic [CMD_W-1:0] op,
			input logic [ELEM_W-1:0] elem, input logic [RANK_W-1:0] rk);
		set_report_t r;
		int          seen;
		case (op)
			CMD_ADD:        member_bits[elem] = 1'b1;
			CMD_REMOVE:     member_bits[elem] = 1'b0;
			CMD_CLEAR:      member_bits = '0;
			CMD_COMPLEMENT: member_bits = ~member_bits;
			default:        ;
		endcase
		r = '0;
		r.is_member    = member_bits[elem];
		r.member_count = COUNT_W'($countones(member_bits));
		r.is_empty     = (member_bits == '0);
		seen = 0;
		// walk upwards: first member is the lowest, rank-th member for select
		for (int p = 0; p < SET_SIZE; p++) begin
			if (member_bits[p]) begin
				seen++;
				if (seen == 1) begin
					r.lowest_member = POS_W'(p);
					r.lowest_found  = 1'b1;
				end
				if (op == CMD_SELECT && seen == rk) begin
					r.nth_member = POS_W'(p);
					r.nth_found  = 1'b1;
				end
			end
		end
		return r;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	// watch both channels on the rising edge
	always @(posedge clk or negedge arst_n) begin
		set_report_t want;
		set_report_t got;
		if (!arst_n) begin
			member_bits = '0;
			expected_reports.delete();
			outstanding = 0;
		end else begin
			// result beat against the oldest prediction
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(set_report_t)-1:0];
				result_count++;
				if (expected_reports.size() == 0) begin
					$display("%0t: result beat with nothing expected, got %h",
						$time, m_tdata);
					fail_count++;
				end else begin
					want = expected_reports.pop_front();
					check_field("is_member", want.is_member, got.is_member);
					check_field("member_count", want.member_count, got.member_count);
					check_field("is_empty", want.is_empty, got.is_empty);
					check_field("lowest_member", want.lowest_member, got.lowest_member);
					check_field("lowest_found", want.lowest_found, got.lowest_found);
					check_field("nth_member", want.nth_member, got.nth_member);
					check_field("nth_found", want.nth_found, got.nth_found);
				end
			end
			// command beat accepted
			if (s_tvalid && s_tready)
				expected_reports.push_back(report_after(s_tuser,
					s_tdata[ELEM_W-1:0], s_tdata[ELEM_W+RANK_W-1:ELEM_W]));
			outstanding = expected_reports.size();
		end
	end

endmodule

// ===== tb/sv/tb_bitmap_set_engine.sv =====
module tb_bitmap_set_engine
	import bse_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// codes the block treats as a plain test
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	localparam int PHASE_ITEMS = 460;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 45;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;  // element[7:0], rank[16:8], zeros
	logic [2:0]  s_tuser  = '0;  // cmd[2:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // is_member, member_count, is_empty, lowest_member,
	                             // lowest_found, nth_member, nth_found, zeros

	int   fail_count;
	int   outstanding;
	int   result_count;
	int   idle_pct  = 0;
	int   stall_pct = 0;
	logic long_hold = 1'b0;
	logic hold_request = 1'b0;
	int   cmd_tally[8];
	int   win_base;

	bitmap_set_engine DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	bse_report_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.fail_count   (fail_count),
		.outstanding  (outstanding),
		.result_count (result_count)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random stalls, forced low during the long hold
	always @(negedge clk) begin
		m_tready <= !long_hold && ($urandom_range(99) >= stall_pct);
	end

	// long receiver hold, counted here so the sender keeps offering meanwhile
	initial begin
		wait (hold_request);
		@(posedge clk);
		long_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold = 1'b0;
	end

	// hard stop
	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// offer one command beat and wait for it to be taken
	task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [ELEM_W-1:0] elem,
			input logic [RANK_W-1:0] rk);
		@(negedge clk);
		// an idle sender drops valid and holds off until the block is ready and a random draw lets it go
		if ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			do @(negedge clk); while (!s_tready || ($urandom_range(99) < idle_pct));
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {7'd0, rk, elem};
		// ready is stable between edges, so seen high here means taken at the next rise
		while (!s_tready) @(negedge clk);
		@(posedge clk);
		cmd_tally[op]++;
	endtask

	task automatic wait_until_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	// mostly set building and selects, some wholesale changes, a little noise
	task automatic send_random();
		int                 pick;
		logic [CMD_W-1:0]   op;
		logic [ELEM_W-1:0]  elem;
		logic [RANK_W-1:0]  rk;
		pick = $urandom_range(99);
		if (pick < 32)
			op = CMD_ADD;
		else if (pick < 48)
			op = CMD_REMOVE;
		else if (pick < 58)
			op = CMD_TEST;
		else if (pick < 88)
			op = CMD_SELECT;
		else if (pick < 91)
			op = CMD_CLEAR;
		else if (pick < 96)
			op = CMD_COMPLEMENT;
		else
			op = $urandom_range(1) ? CMD_SPARE_LO : CMD_SPARE_HI;
		// a narrow window makes removes and tests land on members
		if ($urandom_range(9) < 6)
			elem = ELEM_W'(win_base + $urandom_range(15));
		else
			elem = ELEM_W'($urandom_range(255));
		pick = $urandom_range(9);
		if (pick < 7)
			rk = RANK_W'($urandom_range(20));
		else if (pick < 9)
			rk = RANK_W'($urandom_range(220, 260));
		else
			rk = RANK_W'($urandom_range(511));
		send_cmd(op, elem, rk);
	endtask

	initial begin
		int phase_idle[4];
		int phase_stall[4];
		phase_idle  = '{0, 48, 0, 29};
		phase_stall = '{0, 0, 48, 29};
		foreach (cmd_tally[i]) cmd_tally[i] = 0;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// directed: empty set, both ends of the range, ranks out of range, full set
		send_cmd(CMD_TEST, 8'd0, 9'd0);
		send_cmd(CMD_SELECT, 8'd0, 9'd1);
		send_cmd(CMD_ADD, 8'd0, 9'd0);
		send_cmd(CMD_ADD, 8'd255, 9'd0);
		send_cmd(CMD_ADD, 8'd128, 9'd0);
		send_cmd(CMD_TEST, 8'd255, 9'd0);
		send_cmd(CMD_SELECT, 8'd0, 9'd0);
		send_cmd(CMD_SELECT, 8'd0, 9'd1);
		send_cmd(CMD_SELECT, 8'd0, 9'd3);
		send_cmd(CMD_SELECT, 8'd0, 9'd4);
		send_cmd(CMD_SELECT, 8'd0, 9'd511);
		send_cmd(CMD_REMOVE, 8'd0, 9'd0);
		send_cmd(CMD_REMOVE, 8'd0, 9'd0);
		send_cmd(CMD_COMPLEMENT, 8'd7, 9'd0);
		send_cmd(CMD_SELECT, 8'd0, 9'd254);
		send_cmd(CMD_SELECT, 8'd0, 9'd255);
		send_cmd(CMD_CLEAR, 8'd128, 9'd0);
		send_cmd(CMD_COMPLEMENT, 8'd255, 9'd0);
		send_cmd(CMD_SELECT, 8'd255, 9'd256);
		send_cmd(CMD_SELECT, 8'd0, 9'd257);
		send_cmd(CMD_SPARE_LO, 8'hAA, 9'h155);
		send_cmd(CMD_SPARE_HI, 8'h55, 9'h0AA);
		send_cmd(CMD_REMOVE, 8'd255, 9'd0);
		send_cmd(CMD_CLEAR, 8'd0, 9'd0);
		wait_until_drained();

		// random phases with different idling, draining between them
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct  = phase_idle[ph];
			stall_pct = phase_stall[ph];
			win_base  = $urandom_range(240);
			if (ph == 0)
				hold_request = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// calm stretches inside the idling phases
				if (ph != 0 && n == PHASE_ITEMS / 2) begin
					idle_pct  = 0;
					stall_pct = 0;
				end else if (ph != 0 && n == PHASE_ITEMS / 2 + 40) begin
					idle_pct  = phase_idle[ph];
					stall_pct = phase_stall[ph];
				end
				if (n % 60 == 59)
					win_base = $urandom_range(240);
				send_random();
			end
			wait_until_drained();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("covered add %0d, remove %0d, test %0d, clear %0d, complement %0d,",
			cmd_tally[CMD_ADD], cmd_tally[CMD_REMOVE], cmd_tally[CMD_TEST],
			cmd_tally[CMD_CLEAR], cmd_tally[CMD_COMPLEMENT]);
		$display("select %0d, spare codes %0d; %0d result beats checked over 4 idling phases",
			cmd_tally[CMD_SELECT], cmd_tally[CMD_SPARE_LO] + cmd_tally[CMD_SPARE_HI],
			result_count);
		if (fail_count == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
